/* hdl/blz_pkg.sv */
// ----------------------------------------------------------------------------
// blz_pkg: shared types and constants
// Status codes, decoder state encoding and the decoder result group.
// ----------------------------------------------------------------------------
package blz_pkg;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_MISMATCH = 4'd2;
  localparam logic [3:0] ST_EMPTY    = 4'd3;
  localparam logic [3:0] ST_UNDERRUN = 4'd4;
  localparam logic [3:0] ST_RUNLONG  = 4'd5;
  localparam logic [3:0] ST_BADREF   = 4'd6;
  localparam logic [3:0] ST_LITOVER  = 4'd7;
  localparam logic [3:0] ST_TOOLARGE = 4'd8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam int FOOTER_BYTES = 12;

  typedef enum logic [4:0] {
    S_IDLE, S_FT_RD, S_FT_WT, S_CHK, S_CP_RD, S_CP_WR, S_PREP,
    S_CTL, S_CTL_WT, S_BIT, S_REF_LO, S_REF_HI, S_REF_CHK,
    S_CPY_RD, S_CPY_WR, S_LIT_WT, S_NEXT, S_DONE
  } blz_state_t;

  typedef struct packed {
    logic       done;
    logic [3:0] status;
  } blz_done_t;

endpackage

/* hdl/blz_ram.sv */
// ----------------------------------------------------------------------------
// blz_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module blz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/blz_core.sv */
// ----------------------------------------------------------------------------
// blz_core: backward decode sequencer
// Reads footer, copies image to the output store, then decodes backward.
// ----------------------------------------------------------------------------
module blz_core #(
  parameter int MEM_DEPTH = 65536,
  parameter int AW = $clog2(MEM_DEPTH),
  parameter int CW = $clog2(MEM_DEPTH + 2)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CW-1:0]         n_in,
  output logic                  busy,
  output blz_pkg::blz_done_t    dn,
  output logic [CW-1:0]         length,
  output logic [AW-1:0]         in_ra,
  input  logic [7:0]            in_rd,
  output logic [AW-1:0]         out_ra,
  input  logic [7:0]            out_rd,
  output logic                  out_we,
  output logic [AW-1:0]         out_wa,
  output logic [7:0]            out_wd
);
  import blz_pkg::*;

  localparam int FW = 34;
  localparam int SW = ((CW > 13) ? CW : 13) + 1;

  blz_state_t  state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt, skip_r, skip_nxt, idx_r, idx_nxt;
  logic [CW-1:0] outi_r, outi_nxt, total_r, total_nxt;
  logic [3:0]  cnt_r, cnt_nxt, st_r, st_nxt;
  logic [95:0] foot_r, foot_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt, vlo_r, vlo_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [4:0]  len_r, len_nxt;
  logic [12:0] off_r, off_nxt;
  logic [FW-1:0] csz, init, addl, n_w, tot_w;
  logic [SW-1:0] src;

  assign csz   = FW'(foot_r[31:0]);
  assign init  = FW'(foot_r[63:32]);
  assign addl  = FW'(foot_r[95:64]);
  assign n_w   = FW'(n_r);
  assign tot_w = n_w + addl;
  assign src   = SW'(outi_r) + SW'(off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r <= n_nxt; i_r <= i_nxt; skip_r <= skip_nxt; idx_r <= idx_nxt;
    outi_r <= outi_nxt; total_r <= total_nxt; cnt_r <= cnt_nxt; st_r <= st_nxt;
    foot_r <= foot_nxt; ctrl_r <= ctrl_nxt; vlo_r <= vlo_nxt; bit_r <= bit_nxt;
    len_r <= len_nxt; off_r <= off_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; i_nxt = i_r; skip_nxt = skip_r; idx_nxt = idx_r;
    outi_nxt = outi_r; total_nxt = total_r; cnt_nxt = cnt_r; st_nxt = st_r;
    foot_nxt = foot_r; ctrl_nxt = ctrl_r; vlo_nxt = vlo_r; bit_nxt = bit_r;
    len_nxt = len_r; off_nxt = off_r;
    in_ra  = '0;
    out_ra = '0;
    out_we = 1'b0;
    out_wa = '0;
    out_wd = '0;
    dn.done   = 1'b0;
    dn.status = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt = n_in;
          if (FW'(n_in) > FW'(MEM_DEPTH)) begin
            st_nxt = ST_TOOLARGE; state_nxt = S_DONE;
          end else if (n_in < CW'(FOOTER_BYTES)) begin
            st_nxt = ST_SHORT; state_nxt = S_DONE;
          end else begin
            cnt_nxt = '0; state_nxt = S_FT_RD;
          end
        end
      end
      S_FT_RD: begin
        in_ra = AW'(n_r - CW'(FOOTER_BYTES) + CW'(cnt_r));
        state_nxt = S_FT_WT;
      end
      S_FT_WT: begin
        foot_nxt = {in_rd, foot_r[95:8]};
        cnt_nxt  = cnt_r + 4'd1;
        state_nxt = (cnt_r == 4'(FOOTER_BYTES - 1)) ? S_CHK : S_FT_RD;
      end
      S_CHK: begin
        if (n_w < csz) begin
          st_nxt = ST_MISMATCH; state_nxt = S_DONE;
        end else if (tot_w > FW'(MEM_DEPTH)) begin
          st_nxt = ST_TOOLARGE; state_nxt = S_DONE;
        end else if (csz + addl == '0) begin
          st_nxt = ST_EMPTY; state_nxt = S_DONE;
        end else begin
          total_nxt = CW'(tot_w); i_nxt = '0; state_nxt = S_CP_RD;
        end
      end
      S_CP_RD: begin
        if (i_r == total_r) begin
          state_nxt = S_PREP;
        end else if (i_r < n_r) begin
          in_ra = AW'(i_r); state_nxt = S_CP_WR;
        end else begin
          out_we = 1'b1; out_wa = AW'(i_r); out_wd = '0;
          i_nxt = i_r + 1'b1;
        end
      end
      S_CP_WR: begin
        out_we = 1'b1; out_wa = AW'(i_r); out_wd = in_rd;
        i_nxt = i_r + 1'b1; state_nxt = S_CP_RD;
      end
      S_PREP: begin
        if (init > csz) begin
          st_nxt = ST_UNDERRUN; state_nxt = S_DONE;
        end else begin
          skip_nxt = n_r - CW'(csz);
          idx_nxt  = CW'(csz - init);
          outi_nxt = total_r;
          state_nxt = S_CTL;
        end
      end
      S_CTL: begin
        if (idx_r == '0) begin
          st_nxt = ST_UNDERRUN; state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r - 1'b1;
          in_ra = AW'(skip_r + idx_r - 1'b1);
          state_nxt = S_CTL_WT;
        end
      end
      S_CTL_WT: begin
        ctrl_nxt = in_rd; bit_nxt = '0; state_nxt = S_BIT;
      end
      S_BIT: begin
        if (ctrl_r[7]) begin
          if (idx_r < CW'(2)) begin
            st_nxt = ST_UNDERRUN; state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r - CW'(2);
            in_ra = AW'(skip_r + idx_r - CW'(2));
            state_nxt = S_REF_LO;
          end
        end else if (outi_r == '0) begin
          st_nxt = ST_LITOVER; state_nxt = S_DONE;
        end else if (idx_r == '0) begin
          st_nxt = ST_UNDERRUN; state_nxt = S_DONE;
        end else begin
          outi_nxt = outi_r - 1'b1;
          idx_nxt  = idx_r - 1'b1;
          in_ra = AW'(skip_r + idx_r - 1'b1);
          state_nxt = S_LIT_WT;
        end
      end
      S_REF_LO: begin
        vlo_nxt = in_rd;
        in_ra = AW'(skip_r + idx_r + 1'b1);
        state_nxt = S_REF_HI;
      end
      S_REF_HI: begin
        len_nxt = 5'(in_rd[7:4]) + 5'd3;
        off_nxt = {1'b0, in_rd[3:0], vlo_r} + 13'd2;
        state_nxt = S_REF_CHK;
      end
      S_REF_CHK: begin
        if (outi_r < CW'(len_r)) begin
          st_nxt = ST_RUNLONG; state_nxt = S_DONE;
        end else begin
          state_nxt = S_CPY_RD;
        end
      end
      S_CPY_RD: begin
        if (len_r == '0) begin
          state_nxt = S_NEXT;
        end else if (src >= SW'(total_r)) begin
          st_nxt = ST_BADREF; state_nxt = S_DONE;
        end else begin
          out_ra = AW'(src); state_nxt = S_CPY_WR;
        end
      end
      S_CPY_WR: begin
        out_we = 1'b1; out_wa = AW'(outi_r - 1'b1); out_wd = out_rd;
        outi_nxt = outi_r - 1'b1;
        len_nxt  = len_r - 5'd1;
        state_nxt = S_CPY_RD;
      end
      S_LIT_WT: begin
        out_we = 1'b1; out_wa = AW'(outi_r); out_wd = in_rd;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        ctrl_nxt = {ctrl_r[6:0], 1'b0};
        if (outi_r == '0) begin
          st_nxt = ST_OK; state_nxt = S_DONE;
        end else if (bit_r == 3'd7) begin
          state_nxt = S_CTL;
        end else begin
          bit_nxt = bit_r + 3'd1; state_nxt = S_BIT;
        end
      end
      S_DONE: begin
        dn.done = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy   = (state_r != S_IDLE);
  assign length = (st_r == ST_OK) ? total_r : '0;

endmodule

/* hdl/backward_lz_decompressor.sv */
// ----------------------------------------------------------------------------
// backward_lz_decompressor: backward LZ image decoder
// Loads a compressed image, decodes it backward, serves output bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : requests. tuser = cmd (0 load, 1 pull), tdata = byte, tlast marks
//           the final compressed byte of an image and starts decoding.
//   out_* : results. tuser = kind (0 status, 1 data), tlast = last byte or a
//           pull past the end, tdata = {data_byte, out_length, status}.
//   Loads can be taken back to back. The final load returns one status
//   result after the decode, which reads the footer, copies the image to the
//   output store, zero-fills the tail, then walks control bytes, literals
//   and back-references; the input and output stores each have one read
//   and one write port. A pull is a registered output store read, then the
//   output register. Pulls during loading are dropped. A load after a
//   decode starts a new image. Reset clears counters and the output valid
//   flag; store contents are undefined until written. A stalled output
//   holds its result; a request is taken once the decoder and any pull
//   read are idle and the output slot is empty or being drained.
// ----------------------------------------------------------------------------
module backward_lz_decompressor #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] cmd
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] status, [20:4] out_length,
                                  // [28:21] data_byte, [31:29] zero
  output logic        out_tuser,  // [0] result_kind
  output logic        out_tlast   // last_out
);
  import blz_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int CW = $clog2(MEM_DEPTH + 2);

  logic          loading_r, loading_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt, rlen_r, rlen_nxt, pp_r, pp_nxt;
  logic          pend_r, pend_nxt, plast_r, plast_nxt, ppast_r, ppast_nxt;
  logic          ov_r, ov_nxt, okind_r, okind_nxt, olast_r, olast_nxt;
  logic [3:0]    ost_r, ost_nxt;
  logic [16:0]   olen_r, olen_nxt;
  logic [7:0]    obyte_r, obyte_nxt;

  logic          acc, start, core_busy;
  logic [CW-1:0] base, n_new;
  blz_done_t     dn;
  logic [CW-1:0] core_len;
  logic [AW-1:0] in_ra, core_out_ra, out_ra, out_wa;
  logic [7:0]    in_rd, out_rd, out_wd;
  logic          out_we, in_we;

  // Output slot free or draining this cycle; decoder and pull read idle.
  assign in_tready = !core_busy && !pend_r && (!ov_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  // A load after a finished decode restarts the image at byte zero.
  assign base  = loading_r ? lcnt_r : '0;
  assign n_new = (base <= CW'(MEM_DEPTH)) ? base + 1'b1 : base;
  assign in_we = acc && (in_tuser == CMD_LOAD) && (base < CW'(MEM_DEPTH));
  assign start = acc && (in_tuser == CMD_LOAD) && in_tlast;

  // Output store read port: decoder owns it while busy, pulls otherwise.
  assign out_ra = core_busy ? core_out_ra : AW'(pp_r);

  always_comb begin
    loading_nxt = loading_r;
    lcnt_nxt = lcnt_r; rlen_nxt = rlen_r; pp_nxt = pp_r;
    pend_nxt = 1'b0; plast_nxt = plast_r; ppast_nxt = ppast_r;
    ov_nxt = ov_r; okind_nxt = okind_r; olast_nxt = olast_r;
    ost_nxt = ost_r; olen_nxt = olen_r; obyte_nxt = obyte_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    if (acc && (in_tuser == CMD_LOAD)) begin
      loading_nxt = !in_tlast;
      lcnt_nxt = n_new;
      rlen_nxt = '0;
      pp_nxt   = '0;
    end else if (acc && !loading_r) begin
      // Pull: fetch byte now; the output register takes it after the read returns.
      pend_nxt = 1'b1;
      if (pp_r < rlen_r) begin
        ppast_nxt = 1'b0;
        plast_nxt = (pp_r + 1'b1 == rlen_r);
        pp_nxt    = pp_r + 1'b1;
      end else begin
        ppast_nxt = 1'b1;
        plast_nxt = 1'b1;
      end
    end

    if (pend_r) begin
      ov_nxt = 1'b1; okind_nxt = KIND_DATA; olast_nxt = plast_r;
      ost_nxt = ST_OK; olen_nxt = '0;
      obyte_nxt = ppast_r ? 8'd0 : out_rd;
    end

    if (dn.done) begin
      rlen_nxt = (dn.status == ST_OK) ? core_len : '0;
      ov_nxt = 1'b1; okind_nxt = KIND_STATUS; olast_nxt = 1'b0;
      ost_nxt = dn.status; olen_nxt = 17'(core_len); obyte_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r <= 1'b1;
      lcnt_r <= '0; rlen_r <= '0; pp_r <= '0;
      pend_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      loading_r <= loading_nxt;
      lcnt_r <= lcnt_nxt; rlen_r <= rlen_nxt; pp_r <= pp_nxt;
      pend_r <= pend_nxt; ov_r <= ov_nxt;
    end
    plast_r <= plast_nxt; ppast_r <= ppast_nxt;
    okind_r <= okind_nxt; olast_r <= olast_nxt;
    ost_r <= ost_nxt; olen_r <= olen_nxt; obyte_r <= obyte_nxt;
  end

  blz_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_in_ram (
    .clk(clk), .we(in_we), .waddr(AW'(base)), .wdata(in_tdata),
    .raddr(in_ra), .rdata(in_rd)
  );

  blz_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_out_ram (
    .clk(clk), .we(out_we), .waddr(out_wa), .wdata(out_wd),
    .raddr(out_ra), .rdata(out_rd)
  );

  blz_core #(.MEM_DEPTH(MEM_DEPTH), .AW(AW), .CW(CW)) u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .n_in(n_new),
    .busy(core_busy), .dn(dn), .length(core_len),
    .in_ra(in_ra), .in_rd(in_rd),
    .out_ra(core_out_ra), .out_rd(out_rd),
    .out_we(out_we), .out_wa(out_wa), .out_wd(out_wd)
  );

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, obyte_r, olen_r, ost_r};

  // No request accepted while the decoder runs.
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> !in_tready) else $error("request taken during decode");

  // A pending pull lands in the output register next cycle.
  a_pull_lands: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> ov_r) else $error("pull result lost");

  // The status result never overwrites a waiting result.
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    dn.done |-> !ov_r) else $error("status overwrote output");

  // Decode start ends the loading phase.
  a_start_ends_load: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !loading_r) else $error("loading phase kept after start");

endmodule

/* verif/blz_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blz_checker: scoreboard for the backward LZ decompressor
// Watches both stream channels, predicts each result from the requests it
// sees and compares every result field by field.
// ----------------------------------------------------------------------------
module blz_checker
  import blz_pkg::*;
#(
  parameter int DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fails,
  output int          pending
);

  typedef struct {
    logic        kind;
    logic [3:0]  status;
    logic [16:0] length;
    logic [7:0]  data;
    logic        last;
  } blz_result_t;

  logic [7:0]    image_mem [DEPTH];
  logic [7:0]    plain_mem [DEPTH];
  longint        load_cnt;
  longint        plain_len;
  longint        pull_ptr;
  logic          loading;
  blz_result_t   result_q[$];

  assign pending = result_q.size();

  function automatic logic [7:0] image_at(longint i);
    return (i < DEPTH) ? image_mem[i] : 8'h00;
  endfunction

  function automatic logic [7:0] plain_at(longint i);
    return (i < DEPTH) ? plain_mem[i] : 8'h00;
  endfunction

  function automatic longint word_at(longint i);
    return longint'(image_at(i)) | (longint'(image_at(i + 1)) << 8) |
           (longint'(image_at(i + 2)) << 16) | (longint'(image_at(i + 3)) << 24);
  endfunction

  // Decode the loaded image backward into plain_mem, return the status.
  function automatic logic [3:0] decode_image();
    longint n, csz, init, extra, total, skip, idx, outi, v, len, off;
    int ctrl;
    logic [7:0] d;
    n = load_cnt;
    if (n > DEPTH) return ST_TOOLARGE;
    if (n < FOOTER_BYTES) return ST_SHORT;
    csz   = word_at(n - 12);
    init  = word_at(n - 8);
    extra = word_at(n - 4);
    if (n < csz) return ST_MISMATCH;
    total = n + extra;
    if (total > DEPTH) return ST_TOOLARGE;
    if (csz + extra == 0) return ST_EMPTY;
    for (longint i = 0; i < total; i++)
      plain_mem[i] = (i < n) ? image_mem[i] : 8'h00;
    skip = n - csz;
    if (init > csz) return ST_UNDERRUN;
    idx  = csz - init;
    outi = total;
    while (outi > 0) begin
      if (idx < 1) return ST_UNDERRUN;
      idx--;
      ctrl = image_at(skip + idx);
      for (int b = 0; b < 8; b++) begin
        if (ctrl & 8'h80) begin
          if (idx < 2) return ST_UNDERRUN;
          idx -= 2;
          v   = longint'(image_at(skip + idx)) | (longint'(image_at(skip + idx + 1)) << 8);
          len = ((v >> 12) & 'hF) + 3;
          off = (v & 'hFFF) + 2;
          if (outi < len) return ST_RUNLONG;
          for (longint j = 0; j < len; j++) begin
            if (outi + off >= total) return ST_BADREF;
            d = plain_at(outi + off);
            outi--;
            plain_mem[outi] = d;
          end
        end else begin
          if (outi < 1) return ST_LITOVER;
          if (idx < 1) return ST_UNDERRUN;
          outi--;
          idx--;
          plain_mem[outi] = image_at(skip + idx);
        end
        ctrl = (ctrl << 1) & 'hFF;
        if (outi == 0) break;
      end
    end
    plain_len = total;
    return ST_OK;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    blz_result_t r, w;
    logic [3:0] st;
    if (!rst_n) begin
      load_cnt  = 0;
      plain_len = 0;
      pull_ptr  = 0;
      loading   = 1'b1;
      result_q.delete();
    end else begin
      // request side: update the model and queue what it predicts
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_LOAD) begin
          if (!loading) begin
            load_cnt  = 0;
            plain_len = 0;
            pull_ptr  = 0;
            loading   = 1'b1;
          end
          if (load_cnt < DEPTH) image_mem[load_cnt] = in_tdata;
          if (load_cnt <= DEPTH) load_cnt++;
          if (in_tlast) begin
            plain_len = 0;
            pull_ptr  = 0;
            st = decode_image();
            if (st != ST_OK) plain_len = 0;
            loading  = 1'b0;
            r.kind   = KIND_STATUS;
            r.status = st;
            r.length = (st == ST_OK) ? plain_len[16:0] : 17'd0;
            r.data   = 8'h00;
            r.last   = 1'b0;
            result_q.push_back(r);
          end
        end else if (!loading) begin
          r.kind   = KIND_DATA;
          r.status = ST_OK;
          r.length = 17'd0;
          if (pull_ptr < plain_len) begin
            r.data = plain_at(pull_ptr);
            r.last = (pull_ptr + 1 == plain_len);
            pull_ptr++;
          end else begin
            r.data = 8'h00;
            r.last = 1'b1;
          end
          result_q.push_back(r);
        end
      end
      // result side
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report("unexpected result", out_tdata, 0);
        end else begin
          w = result_q.pop_front();
          if (out_tuser !== w.kind) report("kind", out_tuser, w.kind);
          if (out_tdata[3:0] !== w.status) report("status", out_tdata[3:0], w.status);
          if (out_tdata[20:4] !== w.length) report("length", out_tdata[20:4], w.length);
          if (out_tdata[28:21] !== w.data) report("data", out_tdata[28:21], w.data);
          if (out_tdata[31:29] !== 3'b000) report("pad bits", out_tdata[31:29], 0);
          if (out_tlast !== w.last) report("last", out_tlast, w.last);
        end
      end
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for backward_lz_decompressor
// Builds compressed images (well-formed streams, corrupted ones, bad footers,
// oversize outputs), pulls the decoded bytes back and lets blz_checker compare
// every result with its own prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import blz_pkg::*;

  localparam int DEPTH      = 65536;
  localparam int RUN_ITEMS  = 1400;
  localparam int QUIET_FROM = 1200;   // last stretch runs without idling
  localparam int IDLE_LIMIT = 20000;  // cycles without any handshake
  localparam int HOLD_CYCLES = 500;   // long receiver hold-off

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] in_byte
  logic        in_tuser = CMD_LOAD;  // [0] cmd
  logic        in_tlast = 1'b0;      // last_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [3:0] status, [20:4] length, [28:21] byte
  logic        out_tuser;            // [0] result_kind
  logic        out_tlast;            // last_out

  int          fails;
  int          pending;
  int          sent = 0;         // requests sent
  int          results_seen = 0;
  int          idle_cnt = 0;
  logic        calm = 1'b0;      // current image sent without gaps
  logic        quiet = 1'b0;     // final part: no idling at all
  logic [7:0]  img[$];           // image under construction
  int          plain_total;      // output size of a well-formed image

  backward_lz_decompressor #(.MEM_DEPTH(DEPTH)) u_dut (.*);

  blz_checker #(.DEPTH(DEPTH)) u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: no handshake on either channel for too long ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (out_tvalid && out_tready) results_seen <= results_seen + 1;

  // Receiver: random stall bursts, one long hold-off to back the block up.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet && !held && results_seen >= 40) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && !calm && $urandom_range(0, 11) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // One request; waits for the handshake. Gaps come as random bursts.
  task automatic send(input logic cmd, input logic [7:0] b, input logic last);
    if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) img.push_back(w[8*i +: 8]);
  endtask

  // Well-formed stream: lead bytes, d stream bytes, footer. Tokens are laid
  // from the top down the way the decoder consumes them.
  task automatic build_stream(input int d, input int extra, input int lead);
    logic [7:0] body[];
    int p, outi, cpos, len, off, maxoff;
    logic [15:0] v;
    logic [7:0] ctrl;
    body = new[d];
    foreach (body[i]) body[i] = $urandom_range(0, 255);
    plain_total = lead + d + FOOTER_BYTES + extra;
    p = d;
    outi = plain_total;
    while (outi > 0 && p > 0) begin
      p--;
      cpos = p;
      ctrl = 8'h00;
      for (int b = 0; b < 8; b++) begin
        if (outi == 0) break;
        maxoff = plain_total - 1 - outi;
        if (outi >= 3 && maxoff >= 2 && p >= 2 && $urandom_range(0, 9) < 7) begin
          len = $urandom_range(3, (outi < 18) ? outi : 18);
          off = $urandom_range(2, (maxoff < 4097) ? maxoff : 4097);
          v = 16'(((len - 3) << 12) | (off - 2));
          p -= 2;
          body[p]     = v[7:0];
          body[p + 1] = v[15:8];
          ctrl |= 8'h80 >> b;
          outi -= len;
        end else if (p >= 1) begin
          p--;
          outi--;
        end else begin
          break;
        end
      end
      body[cpos] = ctrl;
    end
    img.delete();
    repeat (lead) img.push_back($urandom_range(0, 255));
    foreach (body[i]) img.push_back(body[i]);
    push32(d + FOOTER_BYTES);
    push32(FOOTER_BYTES);
    push32(extra);
  endtask

  // Load img (last byte flagged), then issue a number of pulls.
  task automatic run_image(input int pulls, input logic stray);
    for (int i = 0; i < img.size(); i++) begin
      if (stray && $urandom_range(0, 9) == 0) begin
        send(CMD_PULL, $urandom_range(0, 255), $urandom_range(0, 1));
        sent++;
      end
      send(CMD_LOAD, img[i], i == img.size() - 1);
      sent++;
    end
    for (int i = 0; i < pulls; i++) begin
      send(CMD_PULL, $urandom_range(0, 255), $urandom_range(0, 1));
      sent++;
    end
  endtask

  task automatic footer_only(input logic [31:0] csz, input logic [31:0] init,
                             input logic [31:0] extra);
    img.delete();
    push32(csz);
    push32(init);
    push32(extra);
  endtask

  initial begin
    int r, d;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    send(CMD_PULL, 8'hFF, 1'b1);          // pull before any image: dropped
    img.delete();
    img.push_back(8'h00);
    run_image(2, 0);                        // one byte: short footer
    img.delete();
    repeat (11) img.push_back(8'hFF);
    run_image(1, 0);                        // eleven bytes: short footer
    footer_only(0, 0, 0);
    run_image(1, 0);                        // empty
    footer_only(13, 0, 0);
    run_image(1, 0);                        // compressed size beyond image
    img.delete();
    img.push_back(8'h00); img.push_back(8'hF0); img.push_back(8'h80);
    push32(15); push32(12); push32(0);
    run_image(1, 0);                        // run longer than output
    img[1] = 8'h00;
    run_image(1, 0);                        // source at the output end
    footer_only(12, 12, 4);
    run_image(1, 0);                        // no control byte left
    footer_only(12, 13, 0);
    run_image(1, 0);                        // initial index above size
    footer_only(12, 0, 32'hFFFF_FFFF);
    run_image(1, 0);                        // extra size too large
    build_stream(20, 5, 0);
    run_image(plain_total + 2, 0);          // well-formed, pull past the end

    // --- random ---
    while (sent < RUN_ITEMS) begin
      quiet = (sent >= QUIET_FROM);
      calm  = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(3, 50);
      if (r < 68) begin
        build_stream(d, $urandom_range(0, 24),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
        if (r >= 58) img[$urandom_range(0, img.size() - 13)] = $urandom_range(0, 255);
        run_image($urandom_range(plain_total / 2, plain_total + 3), r < 10);
      end else begin
        img.delete();
        if (r < 75) begin
          repeat ($urandom_range(1, 60)) img.push_back($urandom_range(0, 255));
        end else if (r < 79) begin
          repeat ($urandom_range(1, 11)) img.push_back($urandom_range(0, 255));
        end else begin
          repeat (d) img.push_back($urandom_range(0, 255));
          if (r < 84) begin
            push32(d + 12 + $urandom_range(1, 100000)); push32(12); push32(4);
          end else if (r < 89) begin
            push32(d + 12); push32(d + 13 + $urandom_range(0, 1000)); push32(0);
          end else if (r < 93) begin
            push32(0); push32($urandom_range(0, 12)); push32(0);
          end else if (r < 97) begin
            push32(d + 12); push32(12);
            push32(DEPTH - d - 12 + $urandom_range(1, 70000));
          end else begin
            push32($urandom); push32($urandom); push32($urandom);
          end
        end
        run_image($urandom_range(0, 4), 1'b1);
      end
    end
    quiet = 1'b1;
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
